/* rtl/kpg_pkg.sv */
// kpg_pkg: shared constants, register indexes and controller/datapath signal groups
// for the k-permutation generator; no dependencies
package kpg_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_LENGTH  = 8;

  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam int POS_W = 3;
  localparam int SYM_W = 8;
  localparam int NUM_W = 32;
  localparam int SC_W  = 5;
  localparam int WL_W  = 4;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int ALPHA_W = SYM_W * MAX_SYMBOLS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHABET_LOW  = 2'd0,
    REG_ALPHABET_HIGH = 2'd1,
    REG_SYMBOL_COUNT  = 2'd2,
    REG_WORD_LENGTH   = 2'd3
  } kpg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic first;      // load first word
    logic back_init;  // cursor to last position
    logic back;       // one backtrack step
    logic fill;       // fill one position with smallest free symbol
    logic emit;       // load one symbol into the output register
  } kpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_first;
    logic back_found;
    logic cur_zero;
    logic cur_last;
    logic out_free;
  } kpg_stat_t;

endpackage

/* rtl/k_permutation_generator_unit.sv */
// Each input word is a request: restart (bit 0) = 1 returns the first word, else the next word
// in lexicographic order of alphabet index, wrapping to the first after the final word. The
// reply is one output word per symbol. A request is accepted, then the successor search takes
// backtrack steps (up to L) and refills positions (up to L-1), then the symbols are shifted
// out through the output register, which waits on m_tready; a first word skips the search.
// L is the clamped word length. Writes to symbol_count or word_length make the next request
// start again from the first word.
// k_permutation_generator_unit: top level; depends on kpg_pkg, kpg_ctrl, kpg_dp
module k_permutation_generator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kpg_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // restart, zero fill
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // symbol, position, word_number, zero fill
  output logic                          m_tlast,   // last_of_word
  output logic                          m_tuser    // final_word
);
  import kpg_pkg::*;

  kpg_cmd_t         cmd;
  kpg_stat_t        stat;
  logic [SYM_W-1:0] out_symbol;
  logic [POS_W-1:0] out_position;
  logic [NUM_W-1:0] out_number;

  kpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kpg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart      (s_tdata[0]),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_symbol   (out_symbol),
    .out_position (out_position),
    .out_last     (m_tlast),
    .out_final    (m_tuser),
    .out_number   (out_number)
  );

  assign m_tdata = {5'b00000, out_number, out_position, out_symbol};

endmodule

/* rtl/kpg_ctrl.sv */
// kpg_ctrl: sequencer for the k-permutation generator
// depends on kpg_pkg; drives kpg_dp through kpg_cmd_t and reads kpg_stat_t
module kpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  kpg_pkg::kpg_stat_t stat,
  output kpg_pkg::kpg_cmd_t  cmd
);
  import kpg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BACK,
    ST_FILL,
    ST_EMIT
  } state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd           = '0;
    cmd.first     = accept && stat.go_first;
    cmd.back_init = accept && !stat.go_first;
    cmd.back      = (state == ST_BACK);
    cmd.fill      = (state == ST_FILL);
    cmd.emit      = (state == ST_EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= stat.go_first ? ST_EMIT : ST_BACK;
          end
        end
        ST_BACK: begin
          if (stat.back_found) begin
            state <= stat.cur_last ? ST_EMIT : ST_FILL;
          end else if (stat.cur_zero) begin
            state <= ST_EMIT;
          end
        end
        ST_FILL: begin
          if (stat.cur_last) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (stat.out_free && stat.cur_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.first, cmd.back_init, cmd.back, cmd.fill, cmd.emit}))
    else $error("kpg_ctrl: more than one command at once");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("kpg_ctrl: accepted word without work");

  a_back_from_back: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BACK) |-> ($past(state) == ST_BACK || $past(cmd.back_init)))
    else $error("kpg_ctrl: backtrack entered without cursor setup");

endmodule

/* rtl/kpg_dp.sv */
// kpg_dp: configuration registers, position indexes, used mask, word counter
// and output register of the k-permutation generator; depends on kpg_pkg
module kpg_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [kpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kpg_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            restart,
  input  kpg_pkg::kpg_cmd_t               cmd,
  output kpg_pkg::kpg_stat_t              stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [kpg_pkg::SYM_W-1:0]       out_symbol,
  output logic [kpg_pkg::POS_W-1:0]       out_position,
  output logic                            out_last,
  output logic                            out_final,
  output logic [kpg_pkg::NUM_W-1:0]       out_number
);
  import kpg_pkg::*;

  logic [CFG_W-1:0]       alphabet_low;
  logic [CFG_W-1:0]       alphabet_high;
  logic [SC_W-1:0]        symbol_count;
  logic [WL_W-1:0]        word_length;

  logic [IDX_W-1:0]       position_index [MAX_LENGTH];
  logic [MAX_SYMBOLS-1:0] used_mask;
  logic                   started;
  logic [NUM_W-1:0]       word_counter;
  logic [POS_W-1:0]       cursor;

  logic [SC_W-1:0]        eff_n;
  logic [SC_W-1:0]        len_wide;
  logic [WL_W-1:0]        eff_len;
  logic [POS_W-1:0]       last_pos;
  logic [MAX_SYMBOLS-1:0] below_n;
  logic [MAX_SYMBOLS-1:0] above_cur;
  logic [MAX_SYMBOLS-1:0] first_mask;
  logic [IDX_W-1:0]       idx_cur;
  logic [MAX_SYMBOLS-1:0] mask_rm;
  logic [IDX_W:0]         succ;
  logic [IDX_W:0]         free_low;
  logic                   is_final;
  logic                   do_first;
  logic [ALPHA_W-1:0]     alphabet;
  logic [IDX_W-1:0]       emit_idx;

  function automatic logic [IDX_W:0] lowest_one(input logic [MAX_SYMBOLS-1:0] v);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  // effective geometry
  always_comb begin
    if (symbol_count == '0) begin
      eff_n = SC_W'(1);
    end else if (symbol_count > SC_W'(MAX_SYMBOLS)) begin
      eff_n = SC_W'(MAX_SYMBOLS);
    end else begin
      eff_n = symbol_count;
    end
    len_wide = (word_length == '0) ? SC_W'(1) : SC_W'(word_length);
    if (len_wide > eff_n) len_wide = eff_n;
    if (len_wide > SC_W'(MAX_LENGTH)) len_wide = SC_W'(MAX_LENGTH);
    eff_len  = WL_W'(len_wide);
    last_pos = POS_W'(eff_len - WL_W'(1));
  end

  always_comb begin
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      below_n[j]    = (SC_W'(j) < eff_n);
      above_cur[j]  = (IDX_W'(j) > idx_cur);
      first_mask[j] = (SC_W'(j) < SC_W'(eff_len));
    end
  end

  assign idx_cur  = position_index[cursor];
  assign mask_rm  = used_mask & ~(MAX_SYMBOLS'(1) << idx_cur);
  assign succ     = lowest_one(~mask_rm & below_n & above_cur);
  assign free_low = lowest_one(~used_mask & below_n);
  assign do_first = cmd.first || (cmd.back && !succ[IDX_W] && cursor == '0);

  always_comb begin
    is_final = 1'b1;
    for (int p = 0; p < MAX_LENGTH; p++) begin
      if (SC_W'(p) < SC_W'(eff_len) &&
          SC_W'(position_index[p]) != eff_n - SC_W'(1) - SC_W'(p)) begin
        is_final = 1'b0;
      end
    end
  end

  assign alphabet = {alphabet_high, alphabet_low};
  assign emit_idx = position_index[cursor];

  always_comb begin
    stat            = '0;
    stat.go_first   = restart || !started;
    stat.back_found = succ[IDX_W];
    stat.cur_zero   = (cursor == '0);
    stat.cur_last   = (cursor == last_pos);
    stat.out_free   = !out_valid || out_ready;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= '0;
      alphabet_high <= '0;
      symbol_count  <= SC_W'(MAX_SYMBOLS);
      word_length   <= WL_W'(1);
    end else if (cfg_write) begin
      case (kpg_reg_t'(cfg_index))
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        REG_SYMBOL_COUNT:  symbol_count  <= cfg_data[SC_W-1:0];
        REG_WORD_LENGTH:   word_length   <= cfg_data[WL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // enumeration state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < MAX_LENGTH; p++) position_index[p] <= IDX_W'(p);
      used_mask    <= '0;
      started      <= 1'b0;
      word_counter <= '0;
      cursor       <= '0;
    end else begin
      if (do_first) begin
        for (int p = 0; p < MAX_LENGTH; p++) position_index[p] <= IDX_W'(p);
        used_mask    <= first_mask;
        started      <= 1'b1;
        word_counter <= '0;
        cursor       <= '0;
      end else if (cmd.back_init) begin
        cursor <= last_pos;
      end else if (cmd.back) begin
        if (succ[IDX_W]) begin
          position_index[cursor] <= succ[IDX_W-1:0];
          used_mask    <= mask_rm | (MAX_SYMBOLS'(1) << succ[IDX_W-1:0]);
          word_counter <= word_counter + NUM_W'(1);
          cursor       <= (cursor == last_pos) ? '0 : cursor + POS_W'(1);
        end else begin
          used_mask <= mask_rm;
          cursor    <= cursor - POS_W'(1);
        end
      end else if (cmd.fill) begin
        position_index[cursor] <= free_low[IDX_W-1:0];
        used_mask <= used_mask | (MAX_SYMBOLS'(1) << free_low[IDX_W-1:0]);
        cursor    <= (cursor == last_pos) ? '0 : cursor + POS_W'(1);
      end else if (cmd.emit) begin
        cursor <= (cursor == last_pos) ? '0 : cursor + POS_W'(1);
      end
      if (cfg_write && (kpg_reg_t'(cfg_index) == REG_SYMBOL_COUNT ||
                        kpg_reg_t'(cfg_index) == REG_WORD_LENGTH)) begin
        started <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_symbol   <= alphabet[{emit_idx, 3'b000} +: SYM_W];
      out_position <= cursor;
      out_last     <= (cursor == last_pos);
      out_final    <= is_final;
      out_number   <= word_counter;
    end
  end

  a_fill_has_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> free_low[IDX_W])
    else $error("kpg_dp: no free symbol for fill");

  a_mask_size: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> ($countones(used_mask) == int'(eff_len)))
    else $error("kpg_dp: used mask does not match word length");

  a_back_started: assert property (@(posedge clk) disable iff (rst)
    (cmd.back || cmd.fill) |-> started)
    else $error("kpg_dp: successor search before first word");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.back && succ[IDX_W]) |=> (word_counter == $past(word_counter) + NUM_W'(1)))
    else $error("kpg_dp: word counter did not advance");

endmodule
